[src/plt_pkg.sv]
package plt_pkg;

   localparam int DEPTH_DEF = 64;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REPLY
   } state_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_INSERT,
      ACT_DELETE,
      ACT_ROTATE
   } act_type;

   typedef struct packed {
      act_type            act;
      logic signed [31:0] key;
      logic [31:0]        payload;
   } cmd_type;

endpackage

[src/plt_cell.sv]
module plt_cell
   import plt_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [CW-1:0]      pos,
   input  logic signed [31:0] left_key,
   input  logic [31:0]        left_payload,
   input  logic signed [31:0] right_key,
   input  logic [31:0]        right_payload,
   output logic signed [31:0] key,
   output logic [31:0]        payload
);

   localparam logic [CW-1:0] IdxC = CW'(IDX);

   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic [31:0]        payload_ff;
   logic [31:0]        payload_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      case (cmd.act)
         ACT_INSERT: begin
            if (IdxC == pos) begin
               key_in     = cmd.key;
               payload_in = cmd.payload;
            end else if (IdxC > pos) begin
               key_in     = left_key;
               payload_in = left_payload;
            end
         end
         ACT_DELETE: begin
            if (IdxC >= pos) begin
               key_in     = right_key;
               payload_in = right_payload;
            end
         end
         ACT_ROTATE: begin
            key_in     = right_key;
            payload_in = right_payload;
         end
         default: begin
            key_in     = key_ff;
            payload_in = payload_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

[src/plt_ctrl.sv]
module plt_ctrl
   import plt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [CW-1:0]      req_position,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_key_out,
   output logic [31:0]        rsp_payload_out,
   output logic [CW-1:0]      rsp_entry_count,
   output cmd_type            cmd,
   output logic [CW-1:0]      cmd_pos,
   input  logic signed [31:0] head_key,
   input  logic [31:0]        head_payload
);

   localparam int            IW       = $clog2(DEPTH);
   localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
   localparam logic [IW-1:0] LastStep = IW'(DEPTH - 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      step_ff, step_in;
   op_type             op_ff, op_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic signed [31:0] skey_ff, skey_in;
   logic               hit_ff, hit_in;
   logic signed [31:0] hkey_ff, hkey_in;
   logic [31:0]        hpay_ff, hpay_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;
   logic signed [31:0] kout_ff, kout_in;
   logic [31:0]        pout_ff, pout_in;
   logic [CW-1:0]      ecount_ff, ecount_in;

   logic    slot_free;
   logic    accept;
   logic    scan_start;
   op_type  req_op_e;
   logic [CW-1:0] step_ext;

   assign req_op_e  = op_type'(req_op);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign step_ext  = CW'(step_ff);

   assign scan_start = (count_ff != '0) &&
                       ((req_op_e == OP_FIND) ||
                        ((req_op_e == OP_READ) && (req_position < count_ff)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && scan_start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (step_ff == LastStep) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      skey_in      = skey_ff;
      hit_in       = hit_ff;
      hkey_in      = hkey_ff;
      hpay_in      = hpay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      found_in     = found_ff;
      kout_in      = kout_ff;
      pout_in      = pout_ff;
      ecount_in    = ecount_ff;
      cmd.act      = ACT_HOLD;
      cmd.key      = req_key;
      cmd.payload  = req_payload;
      cmd_pos      = req_position;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_op_e;
               pos_in  = req_position;
               skey_in = req_key;
               step_in = '0;
               hit_in  = 1'b0;
               if (!scan_start) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_OK;
                  found_in     = 1'b0;
                  kout_in      = '0;
                  pout_in      = '0;
                  ecount_in    = count_ff;
                  case (req_op_e)
                     OP_INSERT: begin
                        if (count_ff == DepthC) begin
                           status_in = ST_FULL;
                        end else if (req_position > count_ff) begin
                           status_in = ST_RANGE;
                        end else begin
                           cmd.act   = ACT_INSERT;
                           count_in  = count_ff + 1'b1;
                           ecount_in = count_ff + 1'b1;
                        end
                     end
                     OP_DELETE: begin
                        if (count_ff == '0) begin
                           status_in = ST_EMPTY;
                        end else if (req_position >= count_ff) begin
                           status_in = ST_RANGE;
                        end else begin
                           cmd.act   = ACT_DELETE;
                           count_in  = count_ff - 1'b1;
                           ecount_in = count_ff - 1'b1;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           status_in = ST_EMPTY;
                        end else begin
                           status_in = ST_RANGE;
                        end
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            cmd.act = ACT_ROTATE;
            step_in = step_ff + 1'b1;
            if (op_ff == OP_READ) begin
               if (step_ext == pos_ff) begin
                  hit_in  = 1'b1;
                  hkey_in = head_key;
                  hpay_in = head_payload;
               end
            end else if (!hit_ff && (step_ext < count_ff) && (head_key == skey_ff)) begin
               hit_in  = 1'b1;
               hkey_in = head_key;
               hpay_in = head_payload;
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               found_in     = hit_ff && (op_ff == OP_FIND);
               kout_in      = hit_ff ? hkey_ff : '0;
               pout_in      = hit_ff ? hpay_ff : '0;
               ecount_in    = count_ff;
            end
         end
         default: begin
            cmd.act = ACT_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      skey_ff   <= skey_in;
      hit_ff    <= hit_in;
      hkey_ff   <= hkey_in;
      hpay_ff   <= hpay_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      kout_ff   <= kout_in;
      pout_ff   <= pout_in;
      ecount_ff <= ecount_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_key_out     = kout_ff;
   assign rsp_payload_out = pout_ff;
   assign rsp_entry_count = ecount_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("entry count above depth");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without an item");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && (step_ff != LastStep) |=>
         (state_ff == S_SCAN) && (step_ff == $past(step_ff) + 1'b1))
      else $error("scan step skipped");

   a_scan_enters: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op_e == OP_FIND) && (count_ff != '0) |=> state_ff == S_SCAN)
      else $error("find did not start a scan");
`endif

endmodule

[src/positional_list_table.sv]
// Ordered list of up to DEPTH entries (signed 32-bit key, 32-bit payload) held in a row of
// cells. Insert and delete shift the cells in place and answer in the cycle after the item is
// taken. Find and read rotate the whole row once past the head cell, so a successful read
// or a find on a non-empty list offers its result after the S_SCAN and S_REPLY states; failed
// operations and find on an empty list answer in the cycle after they are taken. One item is
// worked on at a time. Entries at or beyond the count hold no defined data.
module positional_list_table
   import plt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [CW-1:0]      req_position,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_key_out,
   output logic [31:0]        rsp_payload_out,
   output logic [CW-1:0]      rsp_entry_count
);

   cmd_type            cmd;
   logic [CW-1:0]      cmd_pos;
   logic signed [31:0] cell_key [DEPTH];
   logic [31:0]        cell_payload [DEPTH];

   plt_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_key_out     (rsp_key_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_entry_count (rsp_entry_count),
      .cmd             (cmd),
      .cmd_pos         (cmd_pos),
      .head_key        (cell_key[0]),
      .head_payload    (cell_payload[0])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int Left  = (i == 0) ? DEPTH - 1 : i - 1;
      localparam int Right = (i == DEPTH - 1) ? 0 : i + 1;

      plt_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .pos           (cmd_pos),
         .left_key      (cell_key[Left]),
         .left_payload  (cell_payload[Left]),
         .right_key     (cell_key[Right]),
         .right_payload (cell_payload[Right]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i])
      );
   end

endmodule
